/* rtl/core/lpw_pkg.sv */
// Package: shared constants, register codes and the arctangent table for the point converter.
`default_nettype none
package lpw_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int INDEX_BITS_DEF = 12;
   localparam int RANGE_BITS_DEF = 16;

   localparam int POS_BITS     = 24;
   localparam int PHASE_BITS   = 32;
   localparam int CORDIC_ITERS = 20;
   localparam int GAIN_BITS    = 30;
   localparam int GAIN_SHIFT   = 14;
   localparam int ROUND_SHIFT  = 16;

   localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 30'd652032874;

   localparam logic signed [POS_BITS-1:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [POS_BITS-1:0] POS_MIN = -24'sh800000;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_START_ANGLE = 2'd0,
      REG_ANGLE_STEP  = 2'd1,
      REG_MIN_RANGE   = 2'd2,
      REG_MAX_RANGE   = 2'd3
   } csr_reg_type;

   // atan(2^-i) in 2^32-per-turn phase units
   function automatic logic [PHASE_BITS-1:0] cordic_atan(input int i);
      logic [PHASE_BITS-1:0] v;
      case (i)
         0:       v = 32'd536870912;
         1:       v = 32'd316933406;
         2:       v = 32'd167458907;
         3:       v = 32'd85004756;
         4:       v = 32'd42667331;
         5:       v = 32'd21354465;
         6:       v = 32'd10679838;
         7:       v = 32'd5340245;
         8:       v = 32'd2670163;
         9:       v = 32'd1335087;
         10:      v = 32'd667544;
         11:      v = 32'd333772;
         12:      v = 32'd166886;
         13:      v = 32'd83443;
         14:      v = 32'd41722;
         15:      v = 32'd20860;
         16:      v = 32'd10430;
         17:      v = 32'd5215;
         18:      v = 32'd2608;
         19:      v = 32'd1304;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/lpw_if.sv */
// Interfaces: sample request channel and point response channel.
`default_nettype none
interface lpw_req_if #(
   parameter int ANGLE_BITS = 16,
   parameter int INDEX_BITS = 12,
   parameter int RANGE_BITS = 16
);
   logic                    valid;
   logic                    ready;
   logic [RANGE_BITS-1:0]   sample_range;
   logic [INDEX_BITS-1:0]   sample_index;
   logic signed [23:0]      pose_x;
   logic signed [23:0]      pose_y;
   logic [ANGLE_BITS-1:0]   pose_heading;

   modport source (output valid, sample_range, sample_index, pose_x, pose_y, pose_heading,
                   input ready);
   modport sink   (input valid, sample_range, sample_index, pose_x, pose_y, pose_heading,
                   output ready);
endinterface

interface lpw_rsp_if #(
   parameter int INDEX_BITS = 12
);
   logic                    valid;
   logic                    ready;
   logic signed [23:0]      point_x;
   logic signed [23:0]      point_y;
   logic [INDEX_BITS-1:0]   point_index;

   modport source (output valid, point_x, point_y, point_index, input ready);
   modport sink   (input valid, point_x, point_y, point_index, output ready);
endinterface
`default_nettype wire

/* rtl/core/lpw_front.sv */
// Front end: range gate, beam angle, start vector scaling and quadrant fold.
`default_nettype none
module lpw_front import lpw_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int RANGE_BITS = RANGE_BITS_DEF,
   parameter int W          = RANGE_BITS_DEF + 18,
   parameter int SIDE_BITS  = 2 * POS_BITS + INDEX_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [ANGLE_BITS-1:0]        start_angle,
   input  wire  [ANGLE_BITS-1:0]        angle_step,
   input  wire  [RANGE_BITS-1:0]        min_range,
   input  wire  [RANGE_BITS-1:0]        max_range,
   input  wire                          up_valid,
   output logic                         up_ready,
   input  wire  [RANGE_BITS-1:0]        up_range,
   input  wire  [INDEX_BITS-1:0]        up_index,
   input  wire  [ANGLE_BITS-1:0]        up_heading,
   input  wire  [SIDE_BITS-1:0]         up_side,
   output logic                         dn_valid,
   input  wire                          dn_ready,
   output logic signed [W-1:0]          dn_x,
   output logic signed [PHASE_BITS-1:0] dn_z,
   output logic [SIDE_BITS-1:0]         dn_side
);
   localparam int XP_BITS = RANGE_BITS + GAIN_BITS;
   localparam int X0_BITS = RANGE_BITS + GAIN_BITS - GAIN_SHIFT;

   // stage 0: products
   logic                         v0_ff;
   logic                         ready0;
   logic                         keep_in;
   logic [X0_BITS-1:0]           x0_ff, x0_in;
   logic [ANGLE_BITS-1:0]        prod_ff, prod_in;
   logic [ANGLE_BITS-1:0]        base_ff, base_in;
   logic [SIDE_BITS-1:0]         side0_ff;
   logic [XP_BITS-1:0]           xprod;
   logic [INDEX_BITS+ANGLE_BITS-1:0] aprod;

   // stage 1: fold
   logic                         v1_ff;
   logic signed [W-1:0]          x1_ff, x1_in;
   logic signed [PHASE_BITS-1:0] z1_ff, z1_in;
   logic [SIDE_BITS-1:0]         side1_ff;
   logic [ANGLE_BITS-1:0]        ang;
   logic [PHASE_BITS-1:0]        phase;
   logic                         fold;
   logic signed [W-1:0]          xs;

   assign ready0   = !v0_ff || !v1_ff || dn_ready;
   assign up_ready = ready0;

   always_comb begin
      keep_in = (up_range > min_range) && (up_range < max_range);
      xprod   = XP_BITS'(up_range) * XP_BITS'(GAIN_Q30);
      x0_in   = xprod[XP_BITS-1:GAIN_SHIFT];
      aprod   = up_index * angle_step;
      prod_in = aprod[ANGLE_BITS-1:0];
      base_in = start_angle + up_heading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (ready0) begin
         v0_ff <= up_valid && keep_in;
      end
      if (ready0 && up_valid) begin
         x0_ff    <= x0_in;
         prod_ff  <= prod_in;
         base_ff  <= base_in;
         side0_ff <= up_side;
      end
   end

   always_comb begin
      ang   = base_ff + prod_ff;
      phase = PHASE_BITS'(ang) << (PHASE_BITS - ANGLE_BITS);
      fold  = phase[PHASE_BITS-1] ^ phase[PHASE_BITS-2];
      xs    = W'(x0_ff);
      x1_in = fold ? -xs : xs;
      z1_in = fold ? {~phase[PHASE_BITS-1], phase[PHASE_BITS-2:0]} : phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (!v1_ff || dn_ready) begin
         v1_ff <= v0_ff;
      end
      if ((!v1_ff || dn_ready) && v0_ff) begin
         x1_ff    <= x1_in;
         z1_ff    <= z1_in;
         side1_ff <= side0_ff;
      end
   end

   assign dn_valid = v1_ff;
   assign dn_x     = x1_ff;
   assign dn_z     = z1_ff;
   assign dn_side  = side1_ff;
endmodule
`default_nettype wire

/* rtl/core/lpw_cordic_cell.sv */
// One rotation cell of the CORDIC chain.
`default_nettype none
module lpw_cordic_cell import lpw_pkg::*; #(
   parameter int W         = RANGE_BITS_DEF + 18,
   parameter int SIDE_BITS = 2 * POS_BITS + INDEX_BITS_DEF,
   parameter int STAGE     = 0
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          up_valid,
   output logic                         up_ready,
   input  wire  signed [W-1:0]          up_x,
   input  wire  signed [W-1:0]          up_y,
   input  wire  signed [PHASE_BITS-1:0] up_z,
   input  wire  [SIDE_BITS-1:0]         up_side,
   output logic                         dn_valid,
   input  wire                          dn_ready,
   output logic signed [W-1:0]          dn_x,
   output logic signed [W-1:0]          dn_y,
   output logic signed [PHASE_BITS-1:0] dn_z,
   output logic [SIDE_BITS-1:0]         dn_side
);
   localparam logic signed [PHASE_BITS-1:0] ATAN = cordic_atan(STAGE);

   logic                         v_ff;
   logic signed [W-1:0]          x_ff, x_in;
   logic signed [W-1:0]          y_ff, y_in;
   logic signed [PHASE_BITS-1:0] z_ff, z_in;
   logic [SIDE_BITS-1:0]         side_ff;
   logic signed [W-1:0]          dx, dy;

   assign up_ready = !v_ff || dn_ready;

   always_comb begin
      dx = up_y >>> STAGE;
      dy = up_x >>> STAGE;
      if (!up_z[PHASE_BITS-1]) begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - ATAN;
      end else begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_ready) begin
         v_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = v_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_z     = z_ff;
   assign dn_side  = side_ff;
endmodule
`default_nettype wire

/* rtl/core/lpw_back.sv */
// Back end: round the rotated vector, add the pose and saturate.
`default_nettype none
module lpw_back import lpw_pkg::*; #(
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int W          = RANGE_BITS_DEF + 18,
   parameter int SIDE_BITS  = 2 * POS_BITS + INDEX_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          up_valid,
   output logic                         up_ready,
   input  wire  signed [W-1:0]          up_x,
   input  wire  signed [W-1:0]          up_y,
   input  wire  [SIDE_BITS-1:0]         up_side,
   output logic                         dn_valid,
   input  wire                          dn_ready,
   output logic signed [POS_BITS-1:0]   dn_x,
   output logic signed [POS_BITS-1:0]   dn_y,
   output logic [INDEX_BITS-1:0]        dn_index
);
   localparam int XR_W  = W - ROUND_SHIFT;
   localparam int SUM_W = ((XR_W > POS_BITS) ? XR_W : POS_BITS) + 1;
   localparam logic signed [W-1:0] HALF = W'(1) << (ROUND_SHIFT - 1);

   logic                       va_ff;
   logic                       ready_a;
   logic signed [XR_W-1:0]     xa_ff, xa_in;
   logic signed [XR_W-1:0]     ya_ff, ya_in;
   logic [SIDE_BITS-1:0]       sidea_ff;
   logic signed [W-1:0]        xt, yt;

   logic                       vb_ff;
   logic signed [POS_BITS-1:0] xb_ff, xb_in;
   logic signed [POS_BITS-1:0] yb_ff, yb_in;
   logic [INDEX_BITS-1:0]      ib_ff;
   logic signed [POS_BITS-1:0] pose_x, pose_y;
   logic signed [SUM_W-1:0]    sx, sy;

   assign ready_a  = !va_ff || !vb_ff || dn_ready;
   assign up_ready = ready_a;

   always_comb begin
      xt    = up_x + HALF;
      yt    = up_y + HALF;
      xa_in = xt[W-1:ROUND_SHIFT];
      ya_in = yt[W-1:ROUND_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (ready_a) begin
         va_ff <= up_valid;
      end
      if (ready_a && up_valid) begin
         xa_ff    <= xa_in;
         ya_ff    <= ya_in;
         sidea_ff <= up_side;
      end
   end

   always_comb begin
      pose_x = sidea_ff[SIDE_BITS-1 -: POS_BITS];
      pose_y = sidea_ff[SIDE_BITS-POS_BITS-1 -: POS_BITS];
      sx     = SUM_W'(pose_x) + SUM_W'(xa_ff);
      sy     = SUM_W'(pose_y) + SUM_W'(ya_ff);
      if (sx > SUM_W'(POS_MAX)) begin
         xb_in = POS_MAX;
      end else if (sx < SUM_W'(POS_MIN)) begin
         xb_in = POS_MIN;
      end else begin
         xb_in = sx[POS_BITS-1:0];
      end
      if (sy > SUM_W'(POS_MAX)) begin
         yb_in = POS_MAX;
      end else if (sy < SUM_W'(POS_MIN)) begin
         yb_in = POS_MIN;
      end else begin
         yb_in = sy[POS_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (!vb_ff || dn_ready) begin
         vb_ff <= va_ff;
      end
      if ((!vb_ff || dn_ready) && va_ff) begin
         xb_ff <= xb_in;
         yb_ff <= yb_in;
         ib_ff <= sidea_ff[INDEX_BITS-1:0];
      end
   end

   assign dn_valid = vb_ff;
   assign dn_x     = xb_ff;
   assign dn_y     = yb_ff;
   assign dn_index = ib_ff;
endmodule
`default_nettype wire

/* rtl/core/lidar_polar_to_world_points.sv */
// Top level: lidar range sample to world point converter.
//
// Each req_if beat carries one range sample, its beam index and the robot
// pose. Samples whose range is strictly between min_range and max_range give
// one rsp_if beat with the saturated world point and the beam index; other
// samples are taken and dropped with no response.
// The csr_ port writes start_angle, angle_step, min_range and max_range by
// index; write only while no sample is in flight.
// Pipeline: 2 front stages, 20 CORDIC cells, 2 output stages. Throughput: one
// sample per cycle while rsp_if.ready stays high, set by the rotation chain
// that does one iteration per cell.
// Every stage is an elastic register: when rsp_if.ready is low the chain
// keeps filling its empty stages and req_if.ready drops only once all are
// full. Reset empties the chain and returns the registers to their defaults
// (max_range all ones, the rest zero).
`default_nettype none
module lidar_polar_to_world_points import lpw_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int RANGE_BITS = RANGE_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   lpw_req_if.sink                              req_if,
   lpw_rsp_if.source                            rsp_if,
   input  wire                                  csr_write_en,
   input  wire  [CSR_INDEX_BITS-1:0]            csr_index,
   input  wire  [((ANGLE_BITS > RANGE_BITS) ? ANGLE_BITS : RANGE_BITS)-1:0] csr_wdata
);
   localparam int W         = RANGE_BITS + 18;
   localparam int SIDE_BITS = 2 * POS_BITS + INDEX_BITS;

   logic [ANGLE_BITS-1:0] start_angle_ff;
   logic [ANGLE_BITS-1:0] angle_step_ff;
   logic [RANGE_BITS-1:0] min_range_ff;
   logic [RANGE_BITS-1:0] max_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= '0;
         angle_step_ff  <= '0;
         min_range_ff   <= '0;
         max_range_ff   <= '1;
      end else if (csr_write_en) begin
         case (csr_reg_type'(csr_index))
            REG_START_ANGLE: start_angle_ff <= csr_wdata[ANGLE_BITS-1:0];
            REG_ANGLE_STEP:  angle_step_ff  <= csr_wdata[ANGLE_BITS-1:0];
            REG_MIN_RANGE:   min_range_ff   <= csr_wdata[RANGE_BITS-1:0];
            REG_MAX_RANGE:   max_range_ff   <= csr_wdata[RANGE_BITS-1:0];
            default: ;
         endcase
      end
   end

   logic                         cv [0:CORDIC_ITERS];
   logic                         cr [0:CORDIC_ITERS];
   logic signed [W-1:0]          cx [0:CORDIC_ITERS];
   logic signed [W-1:0]          cy [0:CORDIC_ITERS];
   logic signed [PHASE_BITS-1:0] cz [0:CORDIC_ITERS];
   logic [SIDE_BITS-1:0]         cs [0:CORDIC_ITERS];
   logic [SIDE_BITS-1:0]         req_side;

   assign req_side = {req_if.pose_x, req_if.pose_y, req_if.sample_index};
   assign cy[0]    = '0;

   lpw_front #(
      .ANGLE_BITS (ANGLE_BITS),
      .INDEX_BITS (INDEX_BITS),
      .RANGE_BITS (RANGE_BITS),
      .W          (W),
      .SIDE_BITS  (SIDE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start_angle (start_angle_ff),
      .angle_step  (angle_step_ff),
      .min_range   (min_range_ff),
      .max_range   (max_range_ff),
      .up_valid    (req_if.valid),
      .up_ready    (req_if.ready),
      .up_range    (req_if.sample_range),
      .up_index    (req_if.sample_index),
      .up_heading  (req_if.pose_heading),
      .up_side     (req_side),
      .dn_valid    (cv[0]),
      .dn_ready    (cr[0]),
      .dn_x        (cx[0]),
      .dn_z        (cz[0]),
      .dn_side     (cs[0])
   );

   for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_cell
      lpw_cordic_cell #(
         .W         (W),
         .SIDE_BITS (SIDE_BITS),
         .STAGE     (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cv[k]),
         .up_ready (cr[k]),
         .up_x     (cx[k]),
         .up_y     (cy[k]),
         .up_z     (cz[k]),
         .up_side  (cs[k]),
         .dn_valid (cv[k+1]),
         .dn_ready (cr[k+1]),
         .dn_x     (cx[k+1]),
         .dn_y     (cy[k+1]),
         .dn_z     (cz[k+1]),
         .dn_side  (cs[k+1])
      );
   end

   lpw_back #(
      .INDEX_BITS (INDEX_BITS),
      .W          (W),
      .SIDE_BITS  (SIDE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .up_valid (cv[CORDIC_ITERS]),
      .up_ready (cr[CORDIC_ITERS]),
      .up_x     (cx[CORDIC_ITERS]),
      .up_y     (cy[CORDIC_ITERS]),
      .up_side  (cs[CORDIC_ITERS]),
      .dn_valid (rsp_if.valid),
      .dn_ready (rsp_if.ready),
      .dn_x     (rsp_if.point_x),
      .dn_y     (rsp_if.point_y),
      .dn_index (rsp_if.point_index)
   );
endmodule
`default_nettype wire
